// File: hw/rtl/fpc_pkg.sv
// Shared types and constants for the frustum plane cull core.
// Used by fpc_ctrl, fpc_datapath and frustum_plane_cull_core.
`default_nettype none

package fpc_pkg;

   localparam int DATA_W         = 48;             // Q31.16 coefficient / coordinate
   localparam int HALF_W         = DATA_W / 2;     // partial product split
   localparam int PROD_W         = 2 * HALF_W + 2; // 25 x 25 signed partial product
   localparam int ACC_W          = 2 * DATA_W + 4; // dot product never overflows
   localparam int TERMS          = 4;              // nx*x, ny*y, nz*z, w*2^F
   localparam int TERM_W         = 2;
   localparam int AXES           = 3;
   localparam int OP_W           = 2;
   localparam int IDX_W          = 3;
   localparam int REQ_TDATA_W    = 344;
   localparam int RSP_TDATA_W    = 8;
   localparam int DEF_NUM_PLANES = 6;
   localparam int DEF_FRAC_BITS  = 16;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_SPHERE = 2'd1,
      OP_BOX    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic              load;         // write plane from the input word
      logic              capture;      // latch test operands, clear cull flag
      logic              box;          // captured item is a box test
      logic              issue;        // start one term into the multiply pipe
      logic [TERM_W-1:0] term;
      logic              first;        // first term of a plane
      logic              last;         // last term of a plane
      logic              result_write; // load output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pipe_busy;
      logic out_full;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/fpc_ctrl.sv
// Sequencer for the frustum plane cull core: accepts words, walks planes and terms.
// Depends on fpc_pkg; drives fpc_datapath through cmd_type / status_type.
`default_nettype none

module fpc_ctrl
   import fpc_pkg::*;
#(
   parameter int NUM_PLANES = DEF_NUM_PLANES,
   parameter int PIDX_W     = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [OP_W-1:0]   req_op,
   output logic                   req_ready,
   input  wire status_type        status,
   output cmd_type                cmd,
   output logic [PIDX_W-1:0]      plane_sel
);

   state_type         state_ff, state_in;
   logic [PIDX_W-1:0] plane_ff, plane_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic              accept;
   logic              last_term;
   logic              last_plane;

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign last_term  = (term_ff == TERM_W'(TERMS - 1));
   assign last_plane = (plane_ff == PIDX_W'(NUM_PLANES - 1));
   assign plane_sel  = plane_ff;

   // next state and counters
   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            plane_in = '0;
            term_in  = '0;
            if (accept) begin
               case (req_op)
                  OP_SPHERE, OP_BOX: state_in = ST_RUN;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_RUN: begin
            term_in = term_ff + TERM_W'(1);
            if (last_term) begin
               term_in  = '0;
               plane_in = plane_ff + PIDX_W'(1);
               if (last_plane) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && !status.out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_LOAD:   cmd.load = 1'b1;
                  OP_SPHERE: cmd.capture = 1'b1;
                  OP_BOX: begin
                     cmd.capture = 1'b1;
                     cmd.box     = 1'b1;
                  end
                  default: cmd.load = 1'b0;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            cmd.term  = term_ff;
            cmd.first = (term_ff == '0);
            cmd.last  = last_term;
         end
         ST_DRAIN: begin
            cmd.result_write = !status.pipe_busy && !status.out_full;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         plane_ff <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         term_ff  <= term_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/fpc_datapath.sv
// Plane store, split 48x48 multiply pipe, accumulator and output register.
// Depends on fpc_pkg; commanded by fpc_ctrl.
`default_nettype none

module fpc_datapath
   import fpc_pkg::*;
#(
   parameter int NUM_PLANES = DEF_NUM_PLANES,
   parameter int FRAC_BITS  = DEF_FRAC_BITS,
   parameter int PIDX_W     = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic [PIDX_W-1:0]        plane_sel,
   input  wire logic [IDX_W-1:0]         load_index,
   input  wire logic signed [DATA_W-1:0] in_a [TERMS],
   input  wire logic signed [DATA_W-1:0] in_b [AXES],
   output status_type                    status,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_visible
);

   localparam logic signed [DATA_W-1:0] ONE_F = DATA_W'(1) << FRAC_BITS;

   logic signed [DATA_W-1:0] plane_ff [NUM_PLANES][TERMS];

   // per-axis coordinate for a non-negative / negative normal; entry 3 is 2^F
   logic signed [DATA_W-1:0] hi_ff [TERMS];
   logic signed [DATA_W-1:0] lo_ff [TERMS];
   logic signed [ACC_W-1:0]  bias_ff;

   // stage 0: operands
   logic                     v0_ff, first0_ff, last0_ff;
   logic signed [DATA_W-1:0] n0_ff, c0_ff;
   logic signed [DATA_W-1:0] n_sel;

   // stage 1: partial products
   logic                     v1_ff, first1_ff, last1_ff;
   logic signed [HALF_W:0]   n_lo, n_hi, c_lo, c_hi;
   logic signed [PROD_W-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;

   // stage 2: full product
   logic                     v2_ff, first2_ff, last2_ff;
   logic signed [ACC_W-1:0]  term_ff, term_in;

   // stage 3: accumulate
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     cull_ff;
   logic                     rsp_valid_ff, visible_ff;

   assign n_sel = plane_ff[plane_sel][cmd.term];

   assign n_lo = {1'b0, n0_ff[HALF_W-1:0]};
   assign n_hi = {n0_ff[DATA_W-1], n0_ff[DATA_W-1:HALF_W]};
   assign c_lo = {1'b0, c0_ff[HALF_W-1:0]};
   assign c_hi = {c0_ff[DATA_W-1], c0_ff[DATA_W-1:HALF_W]};

   assign term_in = ACC_W'(pp_ll_ff)
                  + ((ACC_W'(pp_lh_ff) + ACC_W'(pp_hl_ff)) <<< HALF_W)
                  + (ACC_W'(pp_hh_ff) <<< DATA_W);

   assign acc_in = (first2_ff ? bias_ff : acc_ff) + term_ff;

   assign status.pipe_busy = v0_ff || v1_ff || v2_ff;
   assign status.out_full  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_visible      = visible_ff;

   // plane store, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < NUM_PLANES; e++) begin
            for (int t = 0; t < TERMS; t++) begin
               plane_ff[e][t] <= '0;
            end
         end
      end else if (cmd.load) begin
         for (int e = 0; e < NUM_PLANES; e++) begin
            if (32'(load_index) == e) begin
               for (int t = 0; t < TERMS; t++) begin
                  plane_ff[e][t] <= in_a[t];
               end
            end
         end
      end
   end

   // operand capture; a box keeps the per-axis max and min corner
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int t = 0; t < AXES; t++) begin
            if (cmd.box && (in_b[t] < in_a[t])) begin
               hi_ff[t] <= in_a[t];
               lo_ff[t] <= in_b[t];
            end else if (cmd.box) begin
               hi_ff[t] <= in_b[t];
               lo_ff[t] <= in_a[t];
            end else begin
               hi_ff[t] <= in_a[t];
               lo_ff[t] <= in_a[t];
            end
         end
         hi_ff[TERMS-1] <= ONE_F;
         lo_ff[TERMS-1] <= ONE_F;
         bias_ff <= cmd.box ? '0 : (ACC_W'(in_a[TERMS-1]) <<< FRAC_BITS);
      end
   end

   // multiply pipe payload
   always_ff @(posedge clock) begin
      first0_ff <= cmd.first;
      last0_ff  <= cmd.last;
      n0_ff     <= n_sel;
      // the corner farthest along the normal decides whether all corners are behind
      c0_ff     <= n_sel[DATA_W-1] ? lo_ff[cmd.term] : hi_ff[cmd.term];

      first1_ff <= first0_ff;
      last1_ff  <= last0_ff;
      pp_ll_ff  <= n_lo * c_lo;
      pp_lh_ff  <= n_lo * c_hi;
      pp_hl_ff  <= n_hi * c_lo;
      pp_hh_ff  <= n_hi * c_hi;

      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      term_ff   <= term_in;

      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cull_ff <= 1'b0;
      end else if (v2_ff && last2_ff && acc_in[ACC_W-1]) begin
         cull_ff <= 1'b1;
      end
      if (cmd.result_write) begin
         visible_ff <= !cull_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff <= cmd.issue;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         if (cmd.result_write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/frustum_plane_cull_core.sv
// Top level of the frustum plane cull core: stream ports, word unpacking.
// Depends on fpc_pkg, fpc_ctrl and fpc_datapath.
//
//   port group | dir | tdata (low bit first)                          | tuser
//   req_       | in  | plane_index, ax, ay, az, aw, bx, by, bz, pad   | op
//   rsp_       | out | visible, pad                                   | -
//
// A load word is taken while idle and gives no result. A sphere or box test holds
// off the next word until its result is written to the output register: the
// single split 48x48 multiply pipe takes one term per cycle, four per plane.
// Reset clears the plane store to zero. A finished result waits in the output
// register; the next word is accepted meanwhile, and a test stalls only at its end.
`default_nettype none

module frustum_plane_cull_core
   import fpc_pkg::*;
#(
   parameter int NUM_PLANES = DEF_NUM_PLANES,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // plane_index, ax, ay, az, aw, bx, by, bz
   input  wire logic [OP_W-1:0]        req_tuser,  // op
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata   // visible
);

   localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

   cmd_type                  cmd;
   status_type               status;
   logic [PIDX_W-1:0]        plane_sel;
   logic [IDX_W-1:0]         plane_index;
   logic signed [DATA_W-1:0] in_a [TERMS];
   logic signed [DATA_W-1:0] in_b [AXES];
   logic                     visible;

   assign plane_index = req_tdata[IDX_W-1:0];

   always_comb begin
      for (int t = 0; t < TERMS; t++) begin
         in_a[t] = req_tdata[IDX_W + t*DATA_W +: DATA_W];
      end
      for (int t = 0; t < AXES; t++) begin
         in_b[t] = req_tdata[IDX_W + (TERMS + t)*DATA_W +: DATA_W];
      end
   end

   assign rsp_tdata = {{(RSP_TDATA_W-1){1'b0}}, visible};

   fpc_ctrl #(
      .NUM_PLANES (NUM_PLANES),
      .PIDX_W     (PIDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd),
      .plane_sel (plane_sel)
   );

   fpc_datapath #(
      .NUM_PLANES (NUM_PLANES),
      .FRAC_BITS  (FRAC_BITS),
      .PIDX_W     (PIDX_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .plane_sel   (plane_sel),
      .load_index  (plane_index),
      .in_a        (in_a),
      .in_b        (in_b),
      .status      (status),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_visible (visible)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for frustum_plane_cull_core: directed and random stream words,
// checked against a built-in predictor of the plane store and the cull tests.
// Depends on fpc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb
   import fpc_pkg::*;
();

   localparam int                 NPLANES     = DEF_NUM_PLANES;
   localparam int                 FRAC        = DEF_FRAC_BITS;
   localparam logic [OP_W-1:0]    OP_RESERVED = 2'd3;   // unused opcode, ignored by the core
   localparam logic signed [47:0] VMAX        = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] VMIN        = 48'sh8000_0000_0000;
   localparam logic signed [47:0] UNIT        = 48'sd65536;   // 1.0 in Q31.16
   localparam int                 CYCLE_LIMIT = 400000;
   localparam int                 TEST_CYCLES = 4 * NPLANES + 5;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   idx;
      logic signed [47:0] ax, ay, az, aw, bx, by, bz;
   } cull_word_type;

   typedef struct {
      bit              visible;
      int              seq;
      logic [OP_W-1:0] op;
   } verdict_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // plane_index, ax, ay, az, aw, bx, by, bz
   logic [OP_W-1:0]        req_tuser  = '0;   // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // visible

   frustum_plane_cull_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow of the plane store: nx, ny, nz, w per plane
   logic signed [47:0] plane_coef [NPLANES][4];
   verdict_type        expected_verdicts [$];

   int send_idle_pct     = 0;
   int rsp_idle_pct      = 0;
   int rsp_hold_request  = 0;
   int rsp_hold_left     = 0;
   int error_count       = 0;
   int words_sent        = 0;
   int n_loads           = 0;
   int n_sphere          = 0;
   int n_box             = 0;
   int n_other           = 0;
   int n_checked         = 0;
   int n_visible         = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d results outstanding",
               CYCLE_LIMIT, expected_verdicts.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------- predictor

   function automatic logic signed [127:0] plane_distance(input int k,
         input logic signed [47:0] x, input logic signed [47:0] y,
         input logic signed [47:0] z);
      logic signed [127:0] nx, ny, nz, w, px, py, pz;
      nx = 128'(plane_coef[k][0]);
      ny = 128'(plane_coef[k][1]);
      nz = 128'(plane_coef[k][2]);
      w  = 128'(plane_coef[k][3]);
      px = 128'(x);
      py = 128'(y);
      pz = 128'(z);
      return nx * px + ny * py + nz * pz + (w <<< FRAC);
   endfunction

   function automatic bit sphere_visible(input cull_word_type wd);
      logic signed [127:0] r;
      bit vis;
      r   = 128'(wd.aw);
      vis = 1'b1;
      for (int k = 0; k < NPLANES; k++)
         if (plane_distance(k, wd.ax, wd.ay, wd.az) + (r <<< FRAC) < 0)
            vis = 1'b0;
      return vis;
   endfunction

   function automatic bit box_visible(input cull_word_type wd);
      logic signed [47:0] x, y, z;
      int behind;
      bit vis;
      vis = 1'b1;
      for (int k = 0; k < NPLANES; k++) begin
         behind = 0;
         for (int c = 0; c < 8; c++) begin
            x = c[0] ? wd.bx : wd.ax;
            y = c[1] ? wd.by : wd.ay;
            z = c[2] ? wd.bz : wd.az;
            if (plane_distance(k, x, y, z) < 0)
               behind++;
         end
         if (behind == 8)
            vis = 1'b0;
      end
      return vis;
   endfunction

   // update the shadow store and queue the verdict an accepted word should produce
   task automatic apply_word(input cull_word_type wd);
      verdict_type v;
      v.seq = words_sent;
      v.op  = wd.op;
      case (wd.op)
         OP_LOAD: begin
            n_loads++;
            if (wd.idx < NPLANES) begin
               plane_coef[wd.idx][0] = wd.ax;
               plane_coef[wd.idx][1] = wd.ay;
               plane_coef[wd.idx][2] = wd.az;
               plane_coef[wd.idx][3] = wd.aw;
            end
         end
         OP_SPHERE: begin
            n_sphere++;
            v.visible = sphere_visible(wd);
            expected_verdicts.push_back(v);
         end
         OP_BOX: begin
            n_box++;
            v.visible = box_visible(wd);
            expected_verdicts.push_back(v);
         end
         default: n_other++;
      endcase
   endtask

   // ---------------------------------------------------------------- driving

   task automatic send_word(input cull_word_type wd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= wd.op;
      req_tdata  <= {5'b0, wd.bz, wd.by, wd.bx, wd.aw, wd.az, wd.ay, wd.ax, wd.idx};
      do
         @(posedge clock);
      while (!req_tready);
      apply_word(wd);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // result side: random ready, optional long hold-off, in-order compare
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result word visible=%0b with nothing expected",
                                      rsp_tdata[0]));
         end else begin
            v = expected_verdicts.pop_front();
            n_checked++;
            if (v.visible)
               n_visible++;
            if (rsp_tdata[0] !== v.visible)
               report_mismatch($sformatf("word %0d op %0d: visible got %b want %0b",
                                         v.seq, v.op, rsp_tdata[0], v.visible));
         end
      end
      if (rsp_hold_request != 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------- word builders

   function automatic cull_word_type make_word(input logic [OP_W-1:0] op,
         input logic [IDX_W-1:0] idx,
         input logic signed [47:0] ax, input logic signed [47:0] ay,
         input logic signed [47:0] az, input logic signed [47:0] aw,
         input logic signed [47:0] bx, input logic signed [47:0] by,
         input logic signed [47:0] bz);
      cull_word_type wd;
      wd.op = op;
      wd.idx = idx;
      wd.ax = ax;
      wd.ay = ay;
      wd.az = az;
      wd.aw = aw;
      wd.bx = bx;
      wd.by = by;
      wd.bz = bz;
      return wd;
   endfunction

   function automatic logic signed [47:0] rand_word48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(15))
         0: return VMAX;
         1: return VMIN;
         2: return '0;
         3: return -48'sd1;
         default: return r[47:0];
      endcase
   endfunction

   function automatic logic signed [47:0] rand_span(input int unsigned mag);
      logic signed [47:0] v;
      v = 48'($urandom_range(mag));
      if ($urandom_range(1))
         v = -v;
      return v;
   endfunction

   function automatic cull_word_type noise_word();
      return make_word(OP_W'($urandom_range(3)), IDX_W'($urandom_range(7)), rand_word48(),
                       rand_word48(), rand_word48(), rand_word48(), rand_word48(),
                       rand_word48(), rand_word48());
   endfunction

   // roughly box-shaped frustum around the origin, tilted a little per plane
   function automatic cull_word_type frustum_plane(input int k);
      logic signed [47:0] n [3];
      logic signed [47:0] m;
      for (int a = 0; a < 3; a++)
         n[a] = rand_span(1 << 13);
      m = 48'($urandom_range(1 << 17, 1 << 15));
      n[k / 2] = (k % 2 == 0) ? m : -m;
      return make_word(OP_LOAD, IDX_W'(k), n[0], n[1], n[2],
                       48'($urandom_range(1 << 23, 1 << 20)),
                       rand_word48(), rand_word48(), rand_word48());
   endfunction

   task automatic load_frustum();
      int order [NPLANES];
      int j, t;
      for (int k = 0; k < NPLANES; k++)
         order[k] = k;
      for (int k = NPLANES - 1; k > 0; k--) begin
         j = $urandom_range(k);
         t = order[k];
         order[k] = order[j];
         order[j] = t;
      end
      for (int k = 0; k < NPLANES; k++)
         send_word(frustum_plane(order[k]));
   endtask

   function automatic cull_word_type scene_object(input bit is_box);
      logic signed [47:0] lo [3];
      logic signed [47:0] hi [3];
      logic signed [47:0] t, r;
      for (int a = 0; a < 3; a++) begin
         lo[a] = rand_span(1 << 23);
         hi[a] = lo[a] + 48'($urandom_range(1 << 22));
         if ($urandom_range(9) == 0) begin   // swapped bounds
            t = lo[a];
            lo[a] = hi[a];
            hi[a] = t;
         end
      end
      if (is_box)
         return make_word(OP_BOX, IDX_W'($urandom_range(7)), lo[0], lo[1], lo[2],
                          rand_word48(), hi[0], hi[1], hi[2]);
      r = 48'($urandom_range(1 << 22));
      if ($urandom_range(9) == 0)
         r = -r;
      return make_word(OP_SPHERE, IDX_W'($urandom_range(7)), lo[0], lo[1], lo[2], r,
                       rand_word48(), rand_word48(), rand_word48());
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic apply_reset();
      for (int k = 0; k < NPLANES; k++)
         for (int c = 0; c < 4; c++)
            plane_coef[k][c] = '0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   endtask

   // store is all zero after reset: every distance is zero
   task automatic test_zero_store();
      send_word(make_word(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 0, VMAX, VMIN, VMAX, -48'sd1, 0, 0, 0));
      send_word(make_word(OP_BOX, 0, VMIN, VMIN, VMIN, 0, VMAX, VMAX, VMAX));
   endtask

   task automatic test_ignored_words();
      send_word(make_word(OP_LOAD, 6, VMAX, 0, 0, VMIN, 0, 0, 0));
      send_word(make_word(OP_LOAD, 7, VMIN, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX));
      send_word(make_word(OP_RESERVED, 7, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX));
      send_word(make_word(OP_SPHERE, 7, 0, 0, 0, 0, VMAX, VMAX, VMAX));
   endtask

   task automatic test_extremes();
      send_word(make_word(OP_LOAD, 0, VMIN, VMIN, VMIN, VMIN, VMAX, VMAX, VMAX));
      send_word(make_word(OP_SPHERE, 0, VMAX, VMAX, VMAX, VMIN, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 0, VMIN, VMIN, VMIN, VMAX, 0, 0, 0));
      send_word(make_word(OP_BOX, 0, VMIN, VMIN, VMIN, 0, VMAX, VMAX, VMAX));
      send_word(make_word(OP_BOX, 0, VMAX, VMAX, VMAX, 0, VMIN, VMIN, VMIN));
      send_word(make_word(OP_BOX, 0, VMAX, VMAX, VMAX, 0, VMAX, VMAX, VMAX));
      send_word(make_word(OP_LOAD, 5, VMAX, VMAX, VMAX, VMAX, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 0, VMIN, VMIN, VMIN, 0, 0, 0, 0));
   endtask

   // cube of half width 16 around the origin
   task automatic test_unit_cube();
      logic signed [47:0] h;
      h = 16 * UNIT;
      for (int k = 0; k < NPLANES; k++)
         send_word(make_word(OP_LOAD, IDX_W'(k),
                             (k / 2 == 0) ? ((k % 2) ? -UNIT : UNIT) : 0,
                             (k / 2 == 1) ? ((k % 2) ? -UNIT : UNIT) : 0,
                             (k / 2 == 2) ? ((k % 2) ? -UNIT : UNIT) : 0, h, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 1, 20 * UNIT, 0, 0, 2 * UNIT, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 2, 20 * UNIT, 0, 0, 5 * UNIT, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 3, 0, 0, 0, -UNIT, 0, 0, 0));
      send_word(make_word(OP_SPHERE, 4, 0, 0, 0, -20 * UNIT, 0, 0, 0));
      send_word(make_word(OP_BOX, 5, 10 * UNIT, 0, 0, 0, 20 * UNIT, UNIT, UNIT));
      send_word(make_word(OP_BOX, 6, 17 * UNIT, 0, 0, 0, 20 * UNIT, UNIT, UNIT));
      send_word(make_word(OP_BOX, 7, 20 * UNIT, UNIT, UNIT, 0, 17 * UNIT, 0, 0));
   endtask

   // mostly valid frustums with random objects, the rest noise and partial reloads
   task automatic test_random_scenes(input int n_words);
      int stop_at, pick;
      bit need_frustum;
      cull_word_type wd;
      stop_at = words_sent + n_words;
      need_frustum = 1'b1;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (need_frustum || pick < 8) begin
            load_frustum();
            need_frustum = 1'b0;
         end else if (pick < 20) begin
            wd = noise_word();
            send_word(wd);
            if (wd.op == OP_LOAD && wd.idx < NPLANES && $urandom_range(1))
               need_frustum = 1'b1;
         end else if (pick < 26) begin
            send_word(frustum_plane($urandom_range(NPLANES - 1)));
         end else begin
            send_word(scene_object(1'($urandom_range(1))));
         end
      end
   endtask

   // receiver holds off long enough for the core to stall its input
   task automatic test_backpressure();
      load_frustum();
      rsp_hold_request = 250;
      for (int i = 0; i < 12; i++)
         send_word(scene_object(1'(i % 2)));
   endtask

   task automatic test_drain_pause();
      load_frustum();
      for (int i = 0; i < 4; i++)
         send_word(scene_object(1'($urandom_range(1))));
      wait_drained();
      for (int i = 0; i < 4; i++)
         send_word(scene_object(1'($urandom_range(1))));
   endtask

   initial begin
      apply_reset();
      test_zero_store();
      test_ignored_words();
      test_extremes();
      test_unit_cube();

      send_idle_pct = 11;
      rsp_idle_pct  = 53;
      test_random_scenes(200);
      test_backpressure();

      send_idle_pct = 53;
      rsp_idle_pct  = 11;
      test_random_scenes(200);
      test_drain_pause();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_scenes(190);

      wait_drained();
      repeat (2 * TEST_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d plane loads, %0d sphere tests, %0d box tests, %0d unused",
               words_sent, n_loads, n_sphere, n_box, n_other);
      $display("Checked %0d cull results (%0d visible) under mixed stall patterns",
               n_checked, n_visible);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
